// ----- src/dwpid_pkg.sv -----
// Package for the dual-wheel PID speed controller: field widths, register
// indexes and the saturating helpers; the multiplier uses only the widths.
// No dependencies.
`default_nettype none

package dwpid_pkg;

  // Field and datapath widths
  localparam int DATA_W   = 16;
  localparam int GAIN_W   = 16;
  localparam int STEP_W   = 9;
  localparam int INTEG_W  = 32;
  localparam int EXC_W    = 16;
  localparam int MUL_A_W  = 34;
  localparam int MUL_B_W  = GAIN_W + 1;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int ACC_W    = PROD_W + 1;
  localparam int M_W      = 40;
  localparam int FRAC_W   = 16;

  localparam int DATA_MAX = 32767;
  localparam int DATA_MIN = -32768;
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(20);

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP    = 3'd4;

  // Saturate a wide signed value to the 16-bit Q8.8 range.
  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'(DATA_MAX);
    lo = PROD_W'(DATA_MIN);
    if (v > hi) begin
      return DATA_W'(DATA_MAX);
    end else if (v < lo) begin
      return DATA_W'(DATA_MIN);
    end else begin
      return v[DATA_W-1:0];
    end
  endfunction

  // Saturate a 33-bit signed sum to the 32-bit integral range.
  function automatic logic signed [INTEG_W-1:0] sat_integ(input logic signed [INTEG_W:0] v);
    if (v[INTEG_W] != v[INTEG_W-1]) begin
      return v[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      return v[INTEG_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ----- src/dwpid_mul.sv -----
// Shared signed multiplier of the speed controller, with a registered product.
// Depends on dwpid_pkg for the operand widths.
`default_nettype none

module dwpid_mul
  import dwpid_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic signed [MUL_A_W-1:0] a_i,
  input  wire logic signed [MUL_B_W-1:0] b_i,
  output      logic signed [PROD_W-1:0]  p_o
);

  logic signed [PROD_W-1:0] p_d;
  logic signed [PROD_W-1:0] p_q;

  // One product per cycle, registered before any use.
  assign p_d = PROD_W'(a_i) * PROD_W'(b_i);

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ----- src/dual_wheel_pid_speed_control_unit.sv -----
// Dual-wheel PID speed controller: top level with the sequencer and wheel state.
// Depends on dwpid_pkg and dwpid_mul.
//
// Each accepted word is one control tick for both wheels. A small sequencer
// runs the left wheel and then the right wheel through one shared 34x17
// multiplier, each through the states SPD, ERR, MP, MI, MD, AC, SLEW and
// LIM, then waits in DONE until the output register takes the result word
// and goes back to idle before the next word is taken. in_stall_o and the
// low cfg_ready_o show the busy sequencer; the result sits in an output
// register, so the next word may be accepted while it waits. Configuration
// writes are taken only while idle.
`default_nettype none

module dual_wheel_pid_speed_control_unit
  import dwpid_pkg::*;
#(
  parameter int DRIVE_LIMIT = 255,
  parameter int COUNT_WIDTH = 16,
  localparam int DRIVE_W = $clog2(DRIVE_LIMIT + 1) + 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // Configuration write channel
  input  wire logic                     cfg_valid_i,
  output      logic                     cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [DATA_W-1:0]        cfg_data_i,
  // Input channel
  input  wire logic                     in_valid_i,
  output      logic                     in_stall_o,
  input  wire logic signed [DATA_W-1:0] target_left_i,
  input  wire logic signed [DATA_W-1:0] target_right_i,
  input  wire logic [COUNT_WIDTH-1:0]   count_left_i,
  input  wire logic [COUNT_WIDTH-1:0]   count_right_i,
  input  wire logic                     restart_i,
  input  wire logic                     resync_i,
  // Output channel
  output      logic                     out_valid_o,
  input  wire logic                     out_stall_i,
  output      logic signed [DRIVE_W-1:0] drive_left_o,
  output      logic signed [DRIVE_W-1:0] drive_right_o,
  output      logic signed [DATA_W-1:0] speed_left_o,
  output      logic signed [DATA_W-1:0] speed_right_o,
  output      logic                     sat_left_o,
  output      logic                     sat_right_o
);

  // Sequencer state codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SPD  = 4'd1;
  localparam logic [3:0] S_ERR  = 4'd2;
  localparam logic [3:0] S_MP   = 4'd3;
  localparam logic [3:0] S_MI   = 4'd4;
  localparam logic [3:0] S_MD   = 4'd5;
  localparam logic [3:0] S_AC   = 4'd6;
  localparam logic [3:0] S_SLEW = 4'd7;
  localparam logic [3:0] S_LIM  = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  localparam logic signed [M_W-1:0] LIM_P = M_W'(DRIVE_LIMIT);
  localparam logic signed [M_W-1:0] LIM_N = -LIM_P;

  logic [3:0] st_q, st_d;
  logic       wheel_q, wheel_d;
  logic       busy;

  // Configuration registers
  logic [GAIN_W-1:0] scale_q, prop_q, integ_q, deriv_q;
  logic [STEP_W-1:0] step_q;

  // Latched input word
  logic signed [DATA_W-1:0]   tgt_l_q, tgt_r_q;
  logic [COUNT_WIDTH-1:0]     cnt_l_q, cnt_r_q;
  logic                       restart_q, resync_q;

  // Per-wheel controller state
  logic signed [INTEG_W-1:0]  isum_q [2];
  logic signed [DATA_W-1:0]   perr_q [2];
  logic [COUNT_WIDTH-1:0]     prev_q [2];
  logic signed [DRIVE_W-1:0]  drv_q  [2];
  logic signed [DRIVE_W-1:0]  slew_q [2];
  logic                       pend_q [2];
  logic signed [EXC_W-1:0]    exc_q  [2];

  // Working registers of the current wheel
  logic signed [DATA_W-1:0]   speed_q, speed_d;
  logic signed [DATA_W-1:0]   err_q, err_d;
  logic signed [INTEG_W-1:0]  nint_q, nint_d;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic signed [M_W-1:0]      msl_q, msl_d;

  // Results waiting for the output register
  logic signed [DRIVE_W-1:0]  res_drv_q [2];
  logic signed [DATA_W-1:0]   res_spd_q [2];
  logic                       res_sat_q [2];

  // Output register
  logic                       out_valid_q, out_valid_d;
  logic signed [DRIVE_W-1:0]  out_drv_l_q, out_drv_r_q;
  logic signed [DATA_W-1:0]   out_spd_l_q, out_spd_r_q;
  logic                       out_sat_l_q, out_sat_r_q;
  logic                       out_load;

  // Shared multiplier operands
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   prod;

  // Selected wheel's operands
  logic signed [DATA_W-1:0]   tgt_sel;
  logic [COUNT_WIDTH-1:0]     cnt_sel, prev_eff, delta;
  logic signed [DATA_W:0]     err_raw;
  logic signed [ACC_W-1:0]    acc_adj;
  logic signed [M_W-1:0]      inc, m_raw, hi, lo, step_ext;
  logic                       clamp_hi, clamp_lo, clamped;
  logic signed [M_W-1:0]      m_fin, exc_wide;
  logic                       in_acc;

  assign busy        = (st_q != S_IDLE);
  assign in_stall_o  = busy;
  assign cfg_ready_o = !busy;
  assign in_acc      = in_valid_i && !busy;

  // Operand selection for the current wheel
  assign tgt_sel  = wheel_q ? tgt_r_q : tgt_l_q;
  assign cnt_sel  = wheel_q ? cnt_r_q : cnt_l_q;
  assign prev_eff = (restart_q || resync_q) ? cnt_sel : prev_q[wheel_q];
  assign delta    = cnt_sel - prev_eff;

  // Operands of the shared multiplier for each step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_q)
      S_SPD: begin
        mul_a = MUL_A_W'($signed(delta));
        mul_b = $signed({1'b0, scale_q});
      end
      S_MP: begin
        mul_a = MUL_A_W'(err_d);
        mul_b = $signed({1'b0, prop_q});
      end
      S_MI: begin
        mul_a = MUL_A_W'(nint_q);
        if (pend_q[wheel_q]) begin
          mul_a = MUL_A_W'(nint_q) + (MUL_A_W'(exc_q[wheel_q]) <<< 8);
        end
        mul_b = $signed({1'b0, integ_q});
      end
      S_MD: begin
        mul_a = MUL_A_W'(err_q) - MUL_A_W'(perr_q[wheel_q]);
        mul_b = $signed({1'b0, deriv_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  dwpid_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Speed, error and candidate integral
  assign speed_d = sat_data(prod);
  assign err_raw = (DATA_W + 1)'(tgt_sel) - (DATA_W + 1)'(speed_q);
  assign err_d   = sat_data(PROD_W'(err_raw));
  assign nint_d  = sat_integ((INTEG_W + 1)'(isum_q[wheel_q]) + (INTEG_W + 1)'(err_d));

  // Accumulation of the three PID terms; each product arrives in the cycle after its operands.
  always_comb begin
    acc_d = acc_q;
    case (st_q)
      S_MI:    acc_d = ACC_W'(prod);
      S_MD:    acc_d = acc_q + ACC_W'(prod);
      S_AC:    acc_d = acc_q + ACC_W'(prod);
      default: acc_d = acc_q;
    endcase
  end

  // Increment truncated toward zero, then slew limit around the base
  assign acc_adj  = acc_q + (acc_q[ACC_W-1] ? ACC_W'(65535) : ACC_W'(0));
  assign inc      = M_W'(acc_adj >>> FRAC_W);
  assign m_raw    = M_W'(drv_q[wheel_q]) + inc;
  assign step_ext = M_W'($signed({1'b0, step_q}));
  assign hi       = M_W'(slew_q[wheel_q]) + step_ext;
  assign lo       = M_W'(slew_q[wheel_q]) - step_ext;

  always_comb begin
    msl_d = m_raw;
    if (m_raw > hi) begin
      msl_d = hi;
    end
    if (msl_d < lo) begin
      msl_d = lo;
    end
  end

  // Clamp to the drive limit and work out the anti-windup excess
  assign clamp_hi = (msl_q > LIM_P);
  assign clamp_lo = (msl_q < LIM_N);
  assign clamped  = clamp_hi || clamp_lo;
  assign m_fin    = clamp_hi ? LIM_P : (clamp_lo ? LIM_N : msl_q);
  assign exc_wide = m_fin - msl_q;

  // Sequencer
  always_comb begin
    st_d    = st_q;
    wheel_d = wheel_q;
    case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          st_d    = S_SPD;
          wheel_d = 1'b0;
        end
      end
      S_SPD:  st_d = S_ERR;
      S_ERR:  st_d = S_MP;
      S_MP:   st_d = S_MI;
      S_MI:   st_d = S_MD;
      S_MD:   st_d = S_AC;
      S_AC:   st_d = S_SLEW;
      S_SLEW: st_d = S_LIM;
      S_LIM: begin
        if (wheel_q) begin
          st_d = S_DONE;
        end else begin
          st_d    = S_SPD;
          wheel_d = 1'b1;
        end
      end
      S_DONE: begin
        if (out_load) begin
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  // The output register takes the word once it is empty or being taken.
  assign out_load = (st_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      wheel_q     <= 1'b0;
      out_valid_q <= 1'b0;
      scale_q     <= '0;
      prop_q      <= '0;
      integ_q     <= '0;
      deriv_q     <= '0;
      step_q      <= STEP_RESET;
    end else begin
      st_q        <= st_d;
      wheel_q     <= wheel_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && !busy) begin
        case (cfg_index_i)
          CFG_SPEED_SCALE: scale_q <= cfg_data_i;
          CFG_PROP_GAIN:   prop_q  <= cfg_data_i;
          CFG_INTEG_GAIN:  integ_q <= cfg_data_i;
          CFG_DERIV_GAIN:  deriv_q <= cfg_data_i;
          CFG_MAX_STEP:    step_q  <= cfg_data_i[STEP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Per-wheel controller state, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        isum_q[i] <= '0;
        perr_q[i] <= '0;
        prev_q[i] <= '0;
        drv_q[i]  <= '0;
        slew_q[i] <= '0;
        pend_q[i] <= 1'b0;
        exc_q[i]  <= '0;
      end
    end else begin
      if (st_q == S_SPD && restart_q) begin
        isum_q[wheel_q] <= '0;
        perr_q[wheel_q] <= '0;
        slew_q[wheel_q] <= '0;
      end
      if (st_q == S_LIM) begin
        if (clamped) begin
          exc_q[wheel_q] <= EXC_W'(exc_wide);
        end else begin
          isum_q[wheel_q] <= nint_q;
        end
        pend_q[wheel_q] <= clamped;
        perr_q[wheel_q] <= err_q;
        prev_q[wheel_q] <= cnt_sel;
        drv_q[wheel_q]  <= DRIVE_W'(m_fin);
        slew_q[wheel_q] <= DRIVE_W'(m_fin);
      end
    end
  end

  // Payload registers: input word, working values and results
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tgt_l_q   <= target_left_i;
      tgt_r_q   <= target_right_i;
      cnt_l_q   <= count_left_i;
      cnt_r_q   <= count_right_i;
      restart_q <= restart_i;
      resync_q  <= resync_i;
    end
    if (st_q == S_ERR) begin
      speed_q <= speed_d;
    end
    if (st_q == S_MP) begin
      err_q  <= err_d;
      nint_q <= nint_d;
    end
    acc_q <= acc_d;
    if (st_q == S_SLEW) begin
      msl_q <= msl_d;
    end
    if (st_q == S_LIM) begin
      res_drv_q[wheel_q] <= DRIVE_W'(m_fin);
      res_spd_q[wheel_q] <= speed_q;
      res_sat_q[wheel_q] <= clamped;
    end
    if (out_load) begin
      out_drv_l_q <= res_drv_q[0];
      out_drv_r_q <= res_drv_q[1];
      out_spd_l_q <= res_spd_q[0];
      out_spd_r_q <= res_spd_q[1];
      out_sat_l_q <= res_sat_q[0];
      out_sat_r_q <= res_sat_q[1];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign drive_left_o  = out_drv_l_q;
  assign drive_right_o = out_drv_r_q;
  assign speed_left_o  = out_spd_l_q;
  assign speed_right_o = out_spd_r_q;
  assign sat_left_o    = out_sat_l_q;
  assign sat_right_o   = out_sat_r_q;

endmodule

`default_nettype wire

// ----- src/dwpid_checker.sv -----
// Port-level checks for the dual-wheel PID speed controller, with the bind
// that attaches them to the top level. No package dependency.
`default_nettype none

module dwpid_checker #(
  parameter int DRIVE_LIMIT = 255,
  parameter int DRIVE_W     = 9
) (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               cfg_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic [DRIVE_W-1:0] drive_left_o,
  input wire logic [DRIVE_W-1:0] drive_right_o,
  input wire logic               sat_left_o,
  input wire logic               sat_right_o
);

  // An accepted word keeps the block busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && !cfg_ready_o)
    else $error("block not busy after accepting a word");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(drive_left_o)
      && $stable(drive_right_o))
    else $error("stalled result word changed");

  // Drives stay inside the limit.
  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $signed(drive_left_o) <= DRIVE_LIMIT
      && $signed(drive_left_o) >= -DRIVE_LIMIT
      && $signed(drive_right_o) <= DRIVE_LIMIT
      && $signed(drive_right_o) >= -DRIVE_LIMIT)
    else $error("drive outside the limit");

  // A saturation flag means the drive sits on the limit.
  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!sat_left_o || $signed(drive_left_o) == DRIVE_LIMIT
      || $signed(drive_left_o) == -DRIVE_LIMIT)
      && (!sat_right_o || $signed(drive_right_o) == DRIVE_LIMIT
      || $signed(drive_right_o) == -DRIVE_LIMIT))
    else $error("saturation flag without a drive on the limit");

endmodule

bind dual_wheel_pid_speed_control_unit dwpid_checker #(
  .DRIVE_LIMIT (DRIVE_LIMIT),
  .DRIVE_W     (DRIVE_W)
) u_dwpid_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .cfg_ready_o   (cfg_ready_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .drive_left_o  (drive_left_o),
  .drive_right_o (drive_right_o),
  .sat_left_o    (sat_left_o),
  .sat_right_o   (sat_right_o)
);

`default_nettype wire

// ----- verif/dual_wheel_pid_speed_control_unit_test.sv -----
// Self-checking testbench for the dual-wheel PID speed controller.
// Depends on dwpid_pkg and the dual_wheel_pid_speed_control_unit RTL.
// A scoreboard class predicts each tick's result word and checks the outputs.
`timescale 1ns / 100ps

module dual_wheel_pid_speed_control_unit_test;
  import dwpid_pkg::*;

  // One control tick as sent, and one result word as returned.
  typedef struct packed {
    logic signed [DATA_W-1:0] tgt_l;
    logic signed [DATA_W-1:0] tgt_r;
    logic [DATA_W-1:0]        cnt_l;
    logic [DATA_W-1:0]        cnt_r;
    logic                     restart;
    logic                     resync;
  } tick_t;

  typedef struct packed {
    logic signed [STEP_W-1:0] drv_l;
    logic signed [STEP_W-1:0] drv_r;
    logic signed [DATA_W-1:0] spd_l;
    logic signed [DATA_W-1:0] spd_r;
    logic                     sat_l;
    logic                     sat_r;
  } drive_word_t;

  localparam longint DRIVE_MAX = 255;
  localparam longint INT32_HI  = 64'sd2147483647;
  localparam longint INT32_LO  = -64'sd2147483648;
  localparam int     IDLE_PCT  = 34;
  localparam int     STUCK_LIMIT = 4000;

  // Scoreboard: a cycle-free model of both wheels plus the queue of expected words.
  class pid_scoreboard;
    longint integ[2], prev_err[2], drive[2], slew_base[2], excess[2];
    bit     windup[2];
    logic [DATA_W-1:0] prev_cnt[2];
    longint scale, kp, ki, kd, step_lim;
    drive_word_t expected_q[$];
    int errors;
    int words_checked;

    function void clear();
      for (int w = 0; w < 2; w++) begin
        integ[w] = 0; prev_err[w] = 0; drive[w] = 0; slew_base[w] = 0;
        excess[w] = 0; windup[w] = 0; prev_cnt[w] = '0;
      end
      scale = 0; kp = 0; ki = 0; kd = 0; step_lim = 20;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] v);
      case (idx)
        CFG_SPEED_SCALE: scale = longint'(v);
        CFG_PROP_GAIN:   kp = longint'(v);
        CFG_INTEG_GAIN:  ki = longint'(v);
        CFG_DERIV_GAIN:  kd = longint'(v);
        CFG_MAX_STEP:    step_lim = longint'(v[STEP_W-1:0]);
        default: ;
      endcase
    endfunction

    // Advance one wheel by one tick.
    function void wheel_tick(int w, logic signed [DATA_W-1:0] tgt, logic [DATA_W-1:0] cnt,
                             bit rs, bit sy, output logic signed [STEP_W-1:0] drv_o,
                             output logic signed [DATA_W-1:0] spd_o, output logic sat_o);
      logic signed [DATA_W-1:0] diff;
      longint speed, err, new_int, acc, m;
      bit clamped;
      clamped = 0;
      if (rs) begin
        integ[w] = 0; prev_err[w] = 0; slew_base[w] = 0;
      end
      if (rs || sy) prev_cnt[w] = cnt;
      diff = cnt - prev_cnt[w];
      speed = clip(longint'(diff) * scale, -32768, 32767);
      err = clip(longint'(tgt) - speed, -32768, 32767);
      new_int = clip(integ[w] + err, INT32_LO, INT32_HI);
      acc = kp * err;
      if (windup[w]) acc += ki * (new_int + excess[w] * 256);
      else acc += ki * new_int;
      acc += kd * (err - prev_err[w]);
      m = drive[w] + acc / 65536;
      if (m > slew_base[w] + step_lim) m = slew_base[w] + step_lim;
      if (m < slew_base[w] - step_lim) m = slew_base[w] - step_lim;
      windup[w] = 0;
      if (m > DRIVE_MAX) begin
        excess[w] = DRIVE_MAX - m; m = DRIVE_MAX; clamped = 1;
      end else if (m < -DRIVE_MAX) begin
        excess[w] = -DRIVE_MAX - m; m = -DRIVE_MAX; clamped = 1;
      end
      if (clamped) windup[w] = 1;
      else integ[w] = new_int;
      prev_err[w] = err;
      prev_cnt[w] = cnt;
      drive[w] = m;
      slew_base[w] = m;
      drv_o = m[STEP_W-1:0];
      spd_o = speed[DATA_W-1:0];
      sat_o = clamped;
    endfunction

    // Note an accepted tick and queue the word it must produce.
    function void note_tick(tick_t t);
      drive_word_t e;
      wheel_tick(0, t.tgt_l, t.cnt_l, t.restart, t.resync, e.drv_l, e.spd_l, e.sat_l);
      wheel_tick(1, t.tgt_r, t.cnt_r, t.restart, t.resync, e.drv_r, e.spd_r, e.sat_r);
      expected_q.push_back(e);
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      $display("MISMATCH word %0d %s: got %0d, expected %0d", words_checked, what, got, want);
    endtask

    // Check one accepted result word against the oldest expectation.
    task check_result(drive_word_t r);
      drive_word_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("MISMATCH unexpected result word after %0d words", words_checked);
        return;
      end
      e = expected_q.pop_front();
      if (r.drv_l !== e.drv_l) report("drive_left", r.drv_l, e.drv_l);
      if (r.drv_r !== e.drv_r) report("drive_right", r.drv_r, e.drv_r);
      if (r.spd_l !== e.spd_l) report("speed_left", r.spd_l, e.spd_l);
      if (r.spd_r !== e.spd_r) report("speed_right", r.spd_r, e.spd_r);
      if (r.sat_l !== e.sat_l) report("sat_left", r.sat_l, e.sat_l);
      if (r.sat_r !== e.sat_r) report("sat_right", r.sat_r, e.sat_r);
      words_checked++;
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [DATA_W-1:0] target_left_i = '0;
  logic signed [DATA_W-1:0] target_right_i = '0;
  logic [DATA_W-1:0] count_left_i = '0;
  logic [DATA_W-1:0] count_right_i = '0;
  logic restart_i = 1'b0;
  logic resync_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [STEP_W-1:0] drive_left_o, drive_right_o;
  logic signed [DATA_W-1:0] speed_left_o, speed_right_o;
  logic sat_left_o, sat_right_o;

  pid_scoreboard board = new();
  bit calm = 1'b0;
  int ticks_sent = 0;
  int phases_run = 0;
  logic [DATA_W-1:0] last_l = '0;
  logic [DATA_W-1:0] last_r = '0;

  dual_wheel_pid_speed_control_unit dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o,
    .target_left_i, .target_right_i, .count_left_i, .count_right_i,
    .restart_i, .resync_i,
    .out_valid_o, .out_stall_i,
    .drive_left_o, .drive_right_o, .speed_left_o, .speed_right_o,
    .sat_left_o, .sat_right_o
  );

  always #10 clk_i = ~clk_i;

  // Receiver: random stall, and a check of every word taken.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i)
      board.check_result({drive_left_o, drive_right_o, speed_left_o, speed_right_o,
                          sat_left_o, sat_right_o});
    out_stall_i <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // Watchdog on cycles with no handshake at all.
  int stuck = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck <= 0;
    end else if (stuck >= STUCK_LIMIT) begin
      $display("dual_wheel_pid_speed_control_unit_test: done, errors");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  // Send one tick word, with random idle cycles ahead of it unless calm is set.
  task automatic send_tick(tick_t t);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    target_left_i <= t.tgt_l; target_right_i <= t.tgt_r;
    count_left_i <= t.cnt_l; count_right_i <= t.cnt_r;
    restart_i <= t.restart; resync_i <= t.resync;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    board.note_tick(t);
    last_l = t.cnt_l;
    last_r = t.cnt_r;
    ticks_sent++;
  endtask

  // Stop sending and wait for every expected word, then let the block settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Write all five registers while the block is idle.
  task automatic write_regs(logic [15:0] sc, logic [15:0] p, logic [15:0] i,
                            logic [15:0] d, logic [15:0] st);
    logic [15:0] vals[5];
    vals = '{sc, p, i, d, st};
    for (int k = 0; k < 5; k++) begin
      cfg_index_i <= CFG_IDX_W'(k);
      cfg_data_i <= vals[k];
      cfg_valid_i <= 1'b1;
      do @(posedge clk_i); while (!cfg_ready_o);
      board.set_reg(CFG_IDX_W'(k), vals[k]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic tick_t make_tick();
    tick_t t;
    if ($urandom_range(99) < 80) begin
      // Plausible motion: small count steps and moderate targets.
      t.cnt_l = last_l + 16'($signed($urandom_range(600)) - 300);
      t.cnt_r = last_r + 16'($signed($urandom_range(600)) - 300);
      t.tgt_l = 16'($signed($urandom_range(16000)) - 8000);
      t.tgt_r = 16'($signed($urandom_range(16000)) - 8000);
    end else begin
      t.cnt_l = 16'($urandom); t.cnt_r = 16'($urandom);
      t.tgt_l = 16'($urandom); t.tgt_r = 16'($urandom);
    end
    t.restart = ($urandom_range(99) < 5);
    t.resync = ($urandom_range(99) < 6);
    return t;
  endfunction

  task automatic random_phase(logic [15:0] sc, logic [15:0] p, logic [15:0] i,
                              logic [15:0] d, logic [15:0] st, int n);
    drain();
    write_regs(sc, p, i, d, st);
    for (int k = 0; k < n; k++) send_tick(make_tick());
    phases_run++;
  endtask

  initial begin
    board.clear();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: all gains zero, drive stays put.
    send_tick('{16'sh7fff, -16'sh8000, 16'd100, 16'd65500, 1'b0, 1'b0});
    send_tick('{16'sd0, 16'sd0, 16'd0, 16'd0, 1'b1, 1'b0});

    // Directed ticks: extremes, count rollover, saturation, restart and resync.
    drain();
    write_regs(16'd256, 16'd512, 16'd32, 16'd128, 16'd20);
    send_tick('{16'sh7fff, -16'sh8000, 16'd10, 16'hfff6, 1'b0, 1'b0});
    send_tick('{16'sd500, -16'sd500, 16'hfffa, 16'd5, 1'b0, 1'b0});
    send_tick('{16'sd500, -16'sd500, 16'd4, 16'hfffd, 1'b0, 1'b0});
    send_tick('{-16'sh8000, 16'sh7fff, 16'd204, 16'hff00, 1'b0, 1'b0});
    send_tick('{16'sh7fff, -16'sh8000, 16'h80cc, 16'h7f00, 1'b0, 1'b0});
    send_tick('{16'sd0, 16'sd0, 16'h1234, 16'hedcb, 1'b0, 1'b1});
    send_tick('{16'sd1000, 16'sd1000, 16'h1234, 16'hedcb, 1'b1, 1'b1});
    send_tick('{16'sh5555, -16'sh5556, 16'haaaa, 16'h5555, 1'b0, 1'b1});
    send_tick('{-16'sd1, 16'sd1, 16'hffff, 16'h0000, 1'b1, 1'b0});
    // Hard push into the clamp so anti-windup engages, then back off.
    drain();
    write_regs(16'd256, 16'hffff, 16'hffff, 16'hffff, 16'd510);
    for (int k = 0; k < 4; k++) send_tick('{16'sh7fff, -16'sh8000, 16'd0, 16'd0, 1'b0, 1'b1});
    send_tick('{-16'sh8000, 16'sh7fff, 16'd0, 16'd0, 1'b0, 1'b0});
    send_tick('{16'sd0, 16'sd0, 16'd0, 16'd0, 1'b1, 1'b0});
    // Zero slew step: the drive must stay at its base.
    drain();
    write_regs(16'd256, 16'd4096, 16'd64, 16'd0, 16'd0);
    send_tick('{16'sh7fff, -16'sh8000, 16'd50, 16'd50, 1'b0, 1'b0});
    send_tick('{16'sd300, 16'sd300, 16'd60, 16'd40, 1'b0, 1'b0});

    // Random phases over a spread of settings, extremes included.
    random_phase(16'd256, 16'd768, 16'd16, 16'd256, 16'd20, 90);
    calm = 1'b1;
    random_phase(16'd64, 16'd2048, 16'd128, 16'd512, 16'd60, 80);
    calm = 1'b0;
    random_phase(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'd510, 70);
    random_phase(16'd1, 16'd1, 16'd0, 16'd1, 16'd1, 60);
    random_phase(16'($urandom), 16'($urandom_range(4096)), 16'($urandom_range(256)),
                 16'($urandom_range(2048)), 16'($urandom_range(510, 1)), 80);
    // Sender holds off after a phase until every word is back, then sends more ticks.
    random_phase(16'd300, 16'd1024, 16'd48, 16'd384, 16'd35, 40);
    drain();
    for (int k = 0; k < 40; k++) send_tick(make_tick());
    random_phase(16'd0, 16'd0, 16'd0, 16'd0, 16'd20, 70);

    drain();
    $display("Covered %0d ticks over %0d random phases plus directed clamp, rollover",
             ticks_sent, phases_run);
    $display("and zero-step cases; %0d result words checked.", board.words_checked);
    if (board.errors == 0 && board.expected_q.size() == 0) begin
      $display("dual_wheel_pid_speed_control_unit_test: done, clean");
    end else begin
      $display("dual_wheel_pid_speed_control_unit_test: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/dwpid_pkg.sv
src/dwpid_mul.sv
src/dual_wheel_pid_speed_control_unit.sv
src/dwpid_checker.sv
verif/dual_wheel_pid_speed_control_unit_test.sv
